[src/pjtt_pkg.sv]
// ----------------------------------------------------------------------------
// pjtt_pkg
// Shared types and codes of the periodic job timer table.
// ----------------------------------------------------------------------------
package pjtt_pkg;

  localparam int TagW     = 8;
  localparam int DelayW   = 16;
  localparam int OpW      = 2;
  localparam int StatusW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_START    = 2'd0,
    OP_STOP     = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_ENABLED = 3'd1,
    ST_NULL_JOB    = 3'd2,
    ST_FULL        = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_NOT_FOUND   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_FINAL = 4'b1000
  } state_e;

  // one job slot as kept in the slot memory
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [DelayW-1:0] delay;
    logic              one_shot;
    logic              ready;
    logic [DelayW-1:0] counter;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

endpackage

[src/pjtt_in_if.sv]
// ----------------------------------------------------------------------------
// pjtt_in_if
// Command channel of the job timer table: valid/ready plus one command word.
// ----------------------------------------------------------------------------
interface pjtt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  job_tag;
  logic [15:0] delay_ticks;
  logic        one_shot;
  logic        start_ready;

  modport source (
    output valid, operation, job_tag, delay_ticks, one_shot, start_ready,
    input  ready
  );
  modport sink (
    input  valid, operation, job_tag, delay_ticks, one_shot, start_ready,
    output ready
  );
endinterface

[src/pjtt_out_if.sv]
// ----------------------------------------------------------------------------
// pjtt_out_if
// Result channel of the job timer table: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface pjtt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       fired;
  logic [7:0] fired_tag;
  logic       last;

  modport source (
    output valid, status, fired, fired_tag, last,
    input  ready
  );
  modport sink (
    input  valid, status, fired, fired_tag, last,
    output ready
  );
endinterface

[src/periodic_job_timer_table.sv]
// ----------------------------------------------------------------------------
// periodic_job_timer_table
// Table of job slots with tick counters; start, stop, tick and dispatch.
// ----------------------------------------------------------------------------
// A start is taken while idle and its single result is loaded through the
// closing state. Stop, tick and dispatch walk the used slots in order, each
// slot by a read of the slot memory and then an evaluate and write back,
// followed by the closing result. A dispatch firing waits in place while the
// result register is still held by the sink. The slot memory has one
// read and one write port, and the read-then-writeback of each slot sets
// the pace. The block takes a new command only when idle, but a finished
// result may still be waiting.
module periodic_job_timer_table #(
  parameter int JOB_SLOTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  pjtt_in_if.sink    in_i,
  pjtt_out_if.source out_o
);

  localparam int IdxW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int CntW = $clog2(JOB_SLOTS + 1);

  pjtt_pkg::state_e  state_q, state_d;
  pjtt_pkg::op_e     op_q, op_d;
  pjtt_pkg::status_e status_q, status_d;
  logic [pjtt_pkg::TagW-1:0] tag_q, tag_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   used_q, used_d;
  logic              enabled_q;

  logic              out_valid_q, out_valid_d;
  pjtt_pkg::status_e out_status_q, out_status_d;
  logic              out_fired_q, out_fired_d;
  logic [pjtt_pkg::TagW-1:0] out_tag_q, out_tag_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              out_free;

  logic                      ram_we;
  logic [IdxW-1:0]           ram_waddr;
  pjtt_pkg::slot_t           ram_wdata;
  logic                      ram_re;
  logic [pjtt_pkg::SlotW-1:0] ram_rdata;
  pjtt_pkg::slot_t           slot_rd;
  pjtt_pkg::slot_t           slot_new;
  logic                      fire;
  logic                      match;
  logic                      last_slot;
  logic                      accept;
  pjtt_pkg::op_e             in_op;

  pjtt_ram #(
    .WIDTH (pjtt_pkg::SlotW),
    .DEPTH (JOB_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign slot_rd   = pjtt_pkg::slot_t'(ram_rdata);
  assign in_i.ready = (state_q == pjtt_pkg::S_IDLE);
  assign accept    = in_i.valid && in_i.ready;
  assign in_op     = pjtt_pkg::op_e'(in_i.operation);
  assign out_free  = !out_valid_q || out_o.ready;
  assign last_slot = (CntW'(idx_q) + CntW'(1)) == used_q;
  assign ram_re    = (state_q == pjtt_pkg::S_READ);

  // per-slot update of the command in flight
  always_comb begin
    slot_new = slot_rd;
    fire     = 1'b0;
    match    = 1'b0;
    case (op_q)
      pjtt_pkg::OP_STOP: begin
        if (slot_rd.tag == tag_q) begin
          slot_new.ready = 1'b0;
          match          = 1'b1;
        end
      end
      pjtt_pkg::OP_TICK: begin
        slot_new.counter = slot_rd.counter + pjtt_pkg::DelayW'(1);
      end
      pjtt_pkg::OP_DISPATCH: begin
        if (slot_rd.counter == slot_rd.delay && slot_rd.ready) begin
          fire             = 1'b1;
          slot_new.counter = '0;
          if (slot_rd.one_shot) begin
            slot_new.ready = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    status_d     = status_q;
    tag_d        = tag_q;
    idx_d        = idx_q;
    used_d       = used_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = slot_new;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_fired_d  = out_fired_q;
    out_tag_d    = out_tag_q;
    out_last_d   = out_last_q;

    case (state_q)
      pjtt_pkg::S_IDLE: begin
        if (accept) begin
          op_d     = in_op;
          tag_d    = in_i.job_tag;
          idx_d    = '0;
          status_d = pjtt_pkg::ST_OK;
          state_d  = pjtt_pkg::S_FINAL;
          case (in_op)
            pjtt_pkg::OP_START: begin
              if (!enabled_q) begin
                status_d = pjtt_pkg::ST_NOT_ENABLED;
              end else if (in_i.job_tag == '0) begin
                status_d = pjtt_pkg::ST_NULL_JOB;
              end else if (used_q == CntW'(JOB_SLOTS)) begin
                status_d = pjtt_pkg::ST_FULL;
              end else begin
                ram_we              = 1'b1;
                ram_waddr           = used_q[IdxW-1:0];
                ram_wdata.tag       = in_i.job_tag;
                ram_wdata.delay     = in_i.delay_ticks;
                ram_wdata.one_shot  = in_i.one_shot;
                ram_wdata.ready     = in_i.start_ready;
                ram_wdata.counter   = '0;
                used_d              = used_q + CntW'(1);
              end
            end
            pjtt_pkg::OP_STOP: begin
              if (in_i.job_tag == '0) begin
                status_d = pjtt_pkg::ST_NULL_JOB;
              end else begin
                status_d = pjtt_pkg::ST_NOT_FOUND;
                if (used_q != '0) begin
                  state_d = pjtt_pkg::S_READ;
                end
              end
            end
            pjtt_pkg::OP_TICK: begin
              if (used_q != '0) begin
                state_d = pjtt_pkg::S_READ;
              end
            end
            pjtt_pkg::OP_DISPATCH: begin
              if (used_q == '0) begin
                status_d = pjtt_pkg::ST_EMPTY;
              end else begin
                state_d = pjtt_pkg::S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pjtt_pkg::S_READ: begin
        state_d = pjtt_pkg::S_EVAL;
      end
      pjtt_pkg::S_EVAL: begin
        // a firing waits here until the result register frees up
        if (!fire || out_free) begin
          ram_we = 1'b1;
          if (match) begin
            status_d = pjtt_pkg::ST_OK;
          end
          if (fire) begin
            out_load     = 1'b1;
            out_status_d = pjtt_pkg::ST_OK;
            out_fired_d  = 1'b1;
            out_tag_d    = slot_rd.tag;
            out_last_d   = 1'b0;
          end
          if (last_slot) begin
            state_d = pjtt_pkg::S_FINAL;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = pjtt_pkg::S_READ;
          end
        end
      end
      pjtt_pkg::S_FINAL: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = status_q;
          out_fired_d  = 1'b0;
          out_tag_d    = '0;
          out_last_d   = 1'b1;
          state_d      = pjtt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pjtt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pjtt_pkg::S_IDLE;
      used_q      <= '0;
      enabled_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    status_q     <= status_d;
    tag_q        <= tag_d;
    idx_q        <= idx_d;
    out_status_q <= out_status_d;
    out_fired_q  <= out_fired_d;
    out_tag_q    <= out_tag_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.fired     = out_fired_q;
  assign out_o.fired_tag = out_tag_q;
  assign out_o.last      = out_last_q;

  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(JOB_SLOTS))
    else $error("slot fill count beyond table size");

  a_fired_tag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fired_q |-> (out_tag_q != '0) && !out_last_q)
    else $error("firing word with null tag or last set");

  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pjtt_pkg::S_EVAL) |-> (CntW'(idx_q) < used_q))
    else $error("scan index past used slots");

  a_start_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_op == pjtt_pkg::OP_START && enabled_q && in_i.job_tag != '0
      && used_q != CntW'(JOB_SLOTS) |=> used_q == $past(used_q) + CntW'(1))
    else $error("accepted start did not take a slot");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_tag_q))
    else $error("pending result word dropped");

endmodule

[src/pjtt_ram.sv]
// ----------------------------------------------------------------------------
// pjtt_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pjtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
